### design/trs_model_matrix_builder_core_assert.svh
// Assertion macros for the TRS model matrix builder
`ifndef TRS_MODEL_MATRIX_BUILDER_CORE_ASSERT_SVH
`define TRS_MODEL_MATRIX_BUILDER_CORE_ASSERT_SVH
// implication checked on every clock, off during reset
`define TRS_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define TRS_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### design/trs_pkg.sv
// Package: constants, tables and helpers for the TRS matrix builder
package trs_pkg;
    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 28;
    localparam int CW           = 34;   // CORDIC datapath width
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    typedef logic signed [CW-1:0] cval_t;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
    } sc_t;

    typedef struct packed {
        logic signed [31:0] mx, my, mz;
        logic signed [31:0] sx, sy, sz;
    } side_t;

    function automatic logic signed [CW-1:0] atan_tab(input logic [4:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0:  v = 34'sd536870912;  5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;  5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;   5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;   5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;    5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;     5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;     5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;      5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;      5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;       5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;        5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;        5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;         5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;         5'd27: v = 34'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q2.30 x Q2.30 rounded back to Q2.30 (result fits 33 bits)
    function automatic logic signed [32:0] mul30(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b + (66'sd1 <<< 29);
        return p[62:30];
    endfunction

    // rotation entry x scale, rounded and saturated to 32 bits
    function automatic logic signed [31:0] mul_sat(input logic signed [32:0] a,
                                                   input logic signed [31:0] b);
        logic signed [65:0] p;
        logic signed [65:0] q;
        p = a * b + (66'sd1 <<< 29);
        q = p >>> 30;
        if (q > 66'sd2147483647) return 32'sh7fffffff;
        if (q < -66'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction
endpackage

### design/trs_cordic.sv
// Pipelined 28-step CORDIC: three angles in, three sine/cosine pairs out
module trs_cordic import trs_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] ang_x,
    input  logic [ANGLE_BITS-1:0] ang_y,
    input  logic [ANGLE_BITS-1:0] ang_z,
    output sc_t                   sc_x,
    output sc_t                   sc_y,
    output sc_t                   sc_z
);
    cval_t    x_reg [3][CORDIC_STEPS+1];
    cval_t    y_reg [3][CORDIC_STEPS+1];
    cval_t    z_reg [3][CORDIC_STEPS+1];
    logic [1:0] q_reg [3][CORDIC_STEPS+1];
    logic [ANGLE_BITS-1:0] a_in [3];
    sc_t        sc_out [3];

    assign a_in[0] = ang_x;
    assign a_in[1] = ang_y;
    assign a_in[2] = ang_z;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [31:0] turn;
        logic [31:0] rnd;
        logic [1:0]  q;
        logic [31:0] r;
        assign turn = {a_in[k], {(32-ANGLE_BITS){1'b0}}};
        assign rnd  = turn + 32'h2000_0000;
        assign q    = rnd[31:30];
        assign r    = turn - {q, 30'd0};

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k][0] <= CORDIC_GAIN;
                y_reg[k][0] <= '0;
                z_reg[k][0] <= {{2{r[31]}}, r};
                q_reg[k][0] <= q;
            end
        end

        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!z_reg[k][i][CW-1]) begin
                        x_reg[k][i+1] <= x_reg[k][i] - (y_reg[k][i] >>> i);
                        y_reg[k][i+1] <= y_reg[k][i] + (x_reg[k][i] >>> i);
                        z_reg[k][i+1] <= z_reg[k][i] - atan_tab(5'(i));
                    end else begin
                        x_reg[k][i+1] <= x_reg[k][i] + (y_reg[k][i] >>> i);
                        y_reg[k][i+1] <= y_reg[k][i] - (x_reg[k][i] >>> i);
                        z_reg[k][i+1] <= z_reg[k][i] + atan_tab(5'(i));
                    end
                    q_reg[k][i+1] <= q_reg[k][i];
                end
            end
        end

        cval_t xf, yf;
        assign xf = x_reg[k][CORDIC_STEPS];
        assign yf = y_reg[k][CORDIC_STEPS];
        always_comb begin
            case (q_reg[k][CORDIC_STEPS])
                2'd0:    begin sc_out[k].c = xf[31:0];    sc_out[k].s = yf[31:0];    end
                2'd1:    begin sc_out[k].c = -yf[31:0];   sc_out[k].s = xf[31:0];    end
                2'd2:    begin sc_out[k].c = -xf[31:0];   sc_out[k].s = -yf[31:0];   end
                default: begin sc_out[k].c = yf[31:0];    sc_out[k].s = -xf[31:0];   end
            endcase
        end
    end

    assign sc_x = sc_out[0];
    assign sc_y = sc_out[1];
    assign sc_z = sc_out[2];
endmodule

### design/trs_matrix.sv
// Rotation product and scaling pipeline: three registered multiply stages
module trs_matrix import trs_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  sc_t                sc_x,
    input  sc_t                sc_y,
    input  sc_t                sc_z,
    input  logic signed [31:0] st_x,
    input  logic signed [31:0] st_y,
    input  logic signed [31:0] st_z,
    output logic signed [31:0] m_reg [3][3]
);
    logic signed [32:0] cx, sx, cy, sy, cz, sz;
    assign cx = 33'(sc_x.c); assign sx = 33'(sc_x.s);
    assign cy = 33'(sc_y.c); assign sy = 33'(sc_y.s);
    assign cz = 33'(sc_z.c); assign sz = 33'(sc_z.s);

    // stage A: pairwise products
    logic signed [32:0] czsy_reg, szsy_reg, czcy_reg, szcy_reg, szcx_reg, szsx_reg;
    logic signed [32:0] czcx_reg, czsx_reg, cysx_reg, cycx_reg, nsy_reg, sx_a_reg, cx_a_reg;
    logic signed [31:0] sa_reg [3];
    // stage B: rotation entries
    logic signed [32:0] r_reg [3][3];
    logic signed [31:0] sb_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            czsy_reg <= mul30(cz, sy);  szsy_reg <= mul30(sz, sy);
            czcy_reg <= mul30(cz, cy);  szcy_reg <= mul30(sz, cy);
            szcx_reg <= mul30(sz, cx);  szsx_reg <= mul30(sz, sx);
            czcx_reg <= mul30(cz, cx);  czsx_reg <= mul30(cz, sx);
            cysx_reg <= mul30(cy, sx);  cycx_reg <= mul30(cy, cx);
            nsy_reg  <= -sy;            sx_a_reg <= sx;  cx_a_reg <= cx;
            sa_reg[0] <= st_x; sa_reg[1] <= st_y; sa_reg[2] <= st_z;

            r_reg[0][0] <= czcy_reg;
            r_reg[0][1] <= mul30(czsy_reg, sx_a_reg) - szcx_reg;
            r_reg[0][2] <= mul30(czsy_reg, cx_a_reg) + szsx_reg;
            r_reg[1][0] <= szcy_reg;
            r_reg[1][1] <= mul30(szsy_reg, sx_a_reg) + czcx_reg;
            r_reg[1][2] <= mul30(szsy_reg, cx_a_reg) - czsx_reg;
            r_reg[2][0] <= nsy_reg;
            r_reg[2][1] <= cysx_reg;
            r_reg[2][2] <= cycx_reg;
            sb_reg <= sa_reg;

            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    m_reg[r][c] <= mul_sat(r_reg[r][c], sb_reg[c]);
        end
    end
endmodule

### design/trs_model_matrix_builder_core.sv
// Top level of the TRS model matrix builder
//  channel | dir | handshake            | payload
//  s_      | in  | s_valid / s_ready    | move, turn, stretch per axis
//  m_      | out | m_valid / m_ready    | row_index, elem_0..3, last_row
// Pipeline of 33 stages (29 CORDIC, 3 multiply, 1 capture) that moves as one unit.
// Each transaction yields four row transactions, so sustained rate is set by the single output
// port; items overlap in the pipeline. m_valid rises when the holding register captures one.
// Synchronous active-low reset clears valid bits and the row counter only.
// A stalled output freezes the whole pipeline once its last stage holds an item; nothing is dropped or repeated.
module trs_model_matrix_builder_core import trs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_move_x,
    input  logic signed [31:0] s_move_y,
    input  logic signed [31:0] s_move_z,
    input  logic [15:0]        s_turn_x,
    input  logic [15:0]        s_turn_y,
    input  logic [15:0]        s_turn_z,
    input  logic signed [31:0] s_stretch_x,
    input  logic signed [31:0] s_stretch_y,
    input  logic signed [31:0] s_stretch_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_row_index,
    output logic signed [31:0] m_elem_0,
    output logic signed [31:0] m_elem_1,
    output logic signed [31:0] m_elem_2,
    output logic signed [31:0] m_elem_3,
    output logic               m_last_row
);
`include "trs_model_matrix_builder_core_assert.svh"
    localparam int DEPTH = CORDIC_STEPS + 1 + 3;

    logic              en;
    logic [DEPTH-1:0]  vld_reg;
    side_t             side_reg [DEPTH];
    side_t             side_in;
    sc_t               sc_x, sc_y, sc_z;
    logic signed [31:0] m_mat [3][3];
    // output holding
    logic              ov_reg;
    logic [1:0]        row_reg;
    logic signed [31:0] h_reg [3][3];
    side_t             h_side_reg;
    logic              last_acc;

    assign last_acc = ov_reg && m_ready && (row_reg == 2'd3);
    // pipeline advances when the holding register is free or will be, or the last stage is empty
    assign en      = !ov_reg || last_acc || !vld_reg[DEPTH-1];
    assign s_ready = en && aresetn;

    assign side_in = '{mx: s_move_x, my: s_move_y, mz: s_move_z,
                       sx: s_stretch_x, sy: s_stretch_y, sz: s_stretch_z};

    trs_cordic u_cordic (
        .aclk(aclk), .en(en),
        .ang_x(s_turn_x[ANGLE_BITS-1:0]), .ang_y(s_turn_y[ANGLE_BITS-1:0]),
        .ang_z(s_turn_z[ANGLE_BITS-1:0]),
        .sc_x(sc_x), .sc_y(sc_y), .sc_z(sc_z)
    );

    trs_matrix u_matrix (
        .aclk(aclk), .en(en),
        .sc_x(sc_x), .sc_y(sc_y), .sc_z(sc_z),
        .st_x(side_reg[CORDIC_STEPS].sx), .st_y(side_reg[CORDIC_STEPS].sy),
        .st_z(side_reg[CORDIC_STEPS].sz),
        .m_reg(m_mat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DEPTH; i++) side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg  <= 1'b0;
            row_reg <= 2'd0;
        end else begin
            if (ov_reg && m_ready) row_reg <= row_reg + 2'd1;
            if (en) begin
                ov_reg <= vld_reg[DEPTH-1] ? 1'b1 : (ov_reg && !last_acc);
            end else if (last_acc) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vld_reg[DEPTH-1]) begin
            h_reg      <= m_mat;
            h_side_reg <= side_reg[DEPTH-1];
        end
    end

    always_comb begin
        case (row_reg)
            2'd0: begin
                m_elem_0 = h_reg[0][0]; m_elem_1 = h_reg[0][1];
                m_elem_2 = h_reg[0][2]; m_elem_3 = h_side_reg.mx;
            end
            2'd1: begin
                m_elem_0 = h_reg[1][0]; m_elem_1 = h_reg[1][1];
                m_elem_2 = h_reg[1][2]; m_elem_3 = h_side_reg.my;
            end
            2'd2: begin
                m_elem_0 = h_reg[2][0]; m_elem_1 = h_reg[2][1];
                m_elem_2 = h_reg[2][2]; m_elem_3 = h_side_reg.mz;
            end
            default: begin
                m_elem_0 = '0; m_elem_1 = '0; m_elem_2 = '0; m_elem_3 = ONE_Q;
            end
        endcase
    end

    assign m_valid     = ov_reg;
    assign m_row_index = row_reg;
    assign m_last_row  = (row_reg == 2'd3);

    `TRS_ASSERT_IMP(a_row_idle, aclk, aresetn, !ov_reg, row_reg == 2'd0)
    `TRS_ASSERT_NEXT(a_row_step, aclk, aresetn, ov_reg && m_ready && row_reg != 2'd3,
        ov_reg && row_reg == $past(row_reg) + 2'd1)
    `TRS_ASSERT_IMP(a_no_overwrite, aclk, aresetn, ov_reg && !last_acc, !en || !vld_reg[DEPTH-1])
endmodule

### sim/trs_model_matrix_builder_core_tb.sv
// Testbench for the TRS model matrix builder: self-checking matrix rows against a local predictor
module trs_model_matrix_builder_core_tb import trs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] e0, e1, e2, e3;
        logic               last;
    } row_t;

    // Predicts the four matrix rows of each accepted transaction and checks output rows
    class matrix_board;
        row_t   rows_due[$];
        int     fails;

        static function longint asr(longint v, int s);
            return v >>> s;
        endfunction

        static function longint rmul(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        static function longint clamp(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        static function void sincos(logic [15:0] ang, output longint c, output longint s);
            logic [31:0] turn, r;
            logic [1:0]  q;
            longint      x, y, z, dx, dy;
            longint      steps [28] = '{536870912, 316933406, 167458907, 85004756,
                42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
                326, 163, 81, 41, 20, 10, 5};
            turn = {ang, 16'h0};
            q = 2'((turn + 32'h2000_0000) >> 30);
            r = turn - {q, 30'h0};
            z = longint'($signed(r));
            x = 652032874;
            y = 0;
            for (int i = 0; i < 28; i++) begin
                dx = asr(y, i);
                dy = asr(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= steps[i];
                end else begin
                    x += dx; y -= dy; z += steps[i];
                end
            end
            case (q)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void note_item(logic signed [31:0] mv[3], logic [15:0] tn[3],
                                logic signed [31:0] st[3]);
            longint cx, sx, cy, sy, cz, sz;
            longint rot[3][3];
            row_t   r;
            sincos(tn[0], cx, sx);
            sincos(tn[1], cy, sy);
            sincos(tn[2], cz, sz);
            rot[0][0] = rmul(cz, cy);
            rot[0][1] = rmul(rmul(cz, sy), sx) - rmul(sz, cx);
            rot[0][2] = rmul(rmul(cz, sy), cx) + rmul(sz, sx);
            rot[1][0] = rmul(sz, cy);
            rot[1][1] = rmul(rmul(sz, sy), sx) + rmul(cz, cx);
            rot[1][2] = rmul(rmul(sz, sy), cx) - rmul(cz, sx);
            rot[2][0] = -sy;
            rot[2][1] = rmul(cy, sx);
            rot[2][2] = rmul(cy, cx);
            for (int k = 0; k < 3; k++) begin
                r.row  = 2'(k);
                r.e0   = 32'(clamp(rmul(rot[k][0], st[0])));
                r.e1   = 32'(clamp(rmul(rot[k][1], st[1])));
                r.e2   = 32'(clamp(rmul(rot[k][2], st[2])));
                r.e3   = mv[k];
                r.last = 1'b0;
                rows_due.push_back(r);
            end
            r.row = 2'd3; r.e0 = 0; r.e1 = 0; r.e2 = 0; r.e3 = ONE_Q; r.last = 1'b1;
            rows_due.push_back(r);
        endfunction

        function void check_row(row_t got);
            row_t exp_r;
            if (rows_due.size() == 0) begin
                $error("unexpected row transaction, row_index %0d", got.row);
                fails++;
                return;
            end
            exp_r = rows_due.pop_front();
            if (got.row !== exp_r.row) begin
                $error("row_index exp %0d got %0d", exp_r.row, got.row); fails++;
            end
            if (got.e0 !== exp_r.e0) begin
                $error("elem_0 exp %0d got %0d", exp_r.e0, got.e0); fails++;
            end
            if (got.e1 !== exp_r.e1) begin
                $error("elem_1 exp %0d got %0d", exp_r.e1, got.e1); fails++;
            end
            if (got.e2 !== exp_r.e2) begin
                $error("elem_2 exp %0d got %0d", exp_r.e2, got.e2); fails++;
            end
            if (got.e3 !== exp_r.e3) begin
                $error("elem_3 exp %0d got %0d", exp_r.e3, got.e3); fails++;
            end
            if (got.last !== exp_r.last) begin
                $error("last_row exp %0b got %0b", exp_r.last, got.last); fails++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_move_x = '0, s_move_y = '0, s_move_z = '0;
    logic [15:0]        s_turn_x = '0, s_turn_y = '0, s_turn_z = '0;
    logic signed [31:0] s_stretch_x = '0, s_stretch_y = '0, s_stretch_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_row_index;
    logic signed [31:0] m_elem_0, m_elem_1, m_elem_2, m_elem_3;
    logic               m_last_row;

    matrix_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    trs_model_matrix_builder_core u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sample accepted rows at the rising edge
    always @(posedge aclk) begin
        row_t got;
        if (aresetn && m_valid && m_ready) begin
            got.row = m_row_index; got.e0 = m_elem_0; got.e1 = m_elem_1;
            got.e2 = m_elem_2; got.e3 = m_elem_3; got.last = m_last_row;
            board.check_row(got);
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // s_valid stays high between back-to-back transactions; idling drops it
    task automatic send_item(logic signed [31:0] mv[3], logic [15:0] tn[3],
                             logic signed [31:0] st[3]);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_move_x <= mv[0]; s_move_y <= mv[1]; s_move_z <= mv[2];
        s_turn_x <= tn[0]; s_turn_y <= tn[1]; s_turn_z <= tn[2];
        s_stretch_x <= st[0]; s_stretch_y <= st[1]; s_stretch_z <= st[2];
        do @(posedge aclk); while (!s_ready);
        board.note_item(mv, tn, st);
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] rand_scale();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(131072)) - 65536;
            2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    function automatic logic [15:0] rand_turn();
        case ($urandom_range(2))
            0: return 16'($urandom);
            1: return 16'($urandom_range(3) * 16384 + $urandom_range(8) - 4);
            default: return 16'($urandom_range(3) * 8192);
        endcase
    endfunction

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (board.rows_due.size() != 0) @(negedge aclk);
    endtask

    initial begin
        logic signed [31:0] mv[3], st[3];
        logic [15:0]        tn[3];
        int                 phase_pct[4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{25, 25}};
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: field extremes, quadrant boundaries, saturation
        for (int d = 0; d < 20; d++) begin
            for (int k = 0; k < 3; k++) begin
                mv[k] = (d % 3 == 0) ? 32'sh7fffffff : (d % 3 == 1) ? 32'sh80000000 : 32'sd0;
                tn[k] = 16'((d * 4096 + k * 16384) & 16'hffff);
                if (d == 0) tn[k] = 16'h0000;
                if (d == 1) tn[k] = 16'hffff;
                st[k] = (d < 8) ? 32'sh7fffffff : (d < 12) ? 32'sh80000000 : 32'sh0001_0000;
                if (d == 19) st[k] = 32'sd0;
            end
            send_item(mv, tn, st);
        end
        wait_drain();
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_pct[p][0];
            recv_stall_pct = phase_pct[p][1];
            for (int n = 0; n < 53; n++) begin
                for (int k = 0; k < 3; k++) begin
                    mv[k] = $urandom;
                    tn[k] = rand_turn();
                    st[k] = rand_scale();
                end
                send_item(mv, tn, st);
                if (n == 26) wait_drain();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drain();
        repeat (50) @(negedge aclk);
        if (board.fails == 0 && board.rows_due.size() == 0) begin
            $display("trs_model_matrix_builder_core_tb: PASS");
        end else begin
            $display("trs_model_matrix_builder_core_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("trs_model_matrix_builder_core_tb: FAIL");
        $finish;
    end
endmodule

### files.f
+incdir+design
design/trs_pkg.sv
design/trs_cordic.sv
design/trs_matrix.sv
design/trs_model_matrix_builder_core.sv
sim/trs_model_matrix_builder_core_tb.sv
